// File: hdl/text_console_with_scroll_assert.svh
// ----------------------------------------------------------------------------
// text console assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WITH_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_WITH_SCROLL_ASSERT_SVH

`ifndef SYNTH

// check that holds outside reset
`define TCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that holds at every edge, reset included
`define TCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCS_ASSERT(lbl, prop, msg)
`define TCS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// shared constants, types and address helpers of the text console
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CHAR_W     = 8;
  localparam int CELL_W     = 2 * CHAR_W;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd31;

  typedef enum logic [1:0] {
    CMD_TTY   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [CHAR_W-1:0] char_code;
    logic [CHAR_W-1:0] color;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  pos_row;
    logic [COL_W-1:0]  pos_col;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // logical row to physical row through the rotating top-row pointer
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, base};
    if (int'(sum) >= ROWS) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(prow) * COLUMNS + int'(col));
  endfunction

endpackage

`default_nettype wire

// File: hdl/tcs_ram.sv
// ----------------------------------------------------------------------------
// tcs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/tcs_ctrl.sv
// ----------------------------------------------------------------------------
// tcs_ctrl
// command sequencer: cursor, row rotation, fill sweeps and cell store access
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_with_scroll_assert.svh"

module tcs_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  tcs_pkg::item_t                  in_item,
  output logic                            in_stall,
  input  logic [tcs_pkg::CHAR_W-1:0]      tty_attr,
  output logic                            res_valid,
  output tcs_pkg::result_t                res,
  input  logic                            res_take,
  output tcs_pkg::ram_req_t               ram_req,
  input  logic [tcs_pkg::CELL_W-1:0]      ram_rdata
);

  import tcs_pkg::*;

  state_t            state_r, state_nxt;
  item_t             item_r, item_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0] fill_addr_r, fill_addr_nxt;
  logic [ADDR_W-1:0] fill_last_r, fill_last_nxt;
  logic [CELL_W-1:0] fill_cell_r, fill_cell_nxt;
  logic [CELL_W-1:0] res_data_r, res_data_nxt;

  logic              pos_ok;
  logic              row_last;
  logic              col_last;
  logic              advance;
  logic [ADDR_W-1:0] addr_pos;
  logic [ADDR_W-1:0] addr_cur;
  logic [ADDR_W-1:0] addr_top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      base_r      <= '0;
      fill_addr_r <= '0;
      fill_last_r <= ADDR_W'(CELL_COUNT - 1);
      fill_cell_r <= {RESET_COLOR, BLANK_CHAR};
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      base_r      <= base_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_last_r <= fill_last_nxt;
      fill_cell_r <= fill_cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_data_r <= res_data_nxt;
  end

  always_comb begin
    pos_ok   = (int'(item_r.row) < ROWS) && (int'(item_r.col) < COLUMNS);
    row_last = (int'(cur_row_r) == ROWS - 1);
    col_last = (int'(cur_col_r) == COLUMNS - 1);
    addr_pos = cell_addr(phys_row(item_r.row, base_r), item_r.col);
    addr_cur = cell_addr(phys_row(cur_row_r, base_r), cur_col_r);
    addr_top = cell_addr(base_r, '0);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    base_nxt      = base_r;
    fill_addr_nxt = fill_addr_r;
    fill_last_nxt = fill_last_r;
    fill_cell_nxt = fill_cell_r;
    res_data_nxt  = res_data_r;
    ram_req       = '0;
    advance       = 1'b0;
    in_stall      = (state_r != ST_IDLE);
    res_valid     = 1'b0;

    unique case (state_r)
      ST_INIT, ST_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = fill_addr_r;
        ram_req.wdata = fill_cell_r;
        if (fill_addr_r == fill_last_r) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          fill_addr_nxt = ADDR_W'(fill_addr_r + 1'b1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_data_nxt = '0;
        state_nxt    = ST_DONE;
        unique case (item_r.command)
          CMD_TTY: begin
            if (item_r.char_code == NEWLINE_CHAR) begin
              cur_col_nxt = '0;
              advance     = 1'b1;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.waddr = addr_cur;
              ram_req.wdata = {tty_attr, item_r.char_code};
              if (col_last) begin
                cur_col_nxt = '0;
                advance     = 1'b1;
              end else begin
                cur_col_nxt = COL_W'(cur_col_r + 1'b1);
              end
            end
            if (advance) begin
              if (row_last) begin
                // scroll: old top row becomes the new blank bottom row
                base_nxt      = (int'(base_r) == ROWS - 1) ? '0 : ROW_W'(base_r + 1'b1);
                fill_addr_nxt = addr_top;
                fill_last_nxt = ADDR_W'(addr_top + ADDR_W'(COLUMNS - 1));
                fill_cell_nxt = {tty_attr, BLANK_CHAR};
                state_nxt     = ST_FILL;
              end else begin
                cur_row_nxt = ROW_W'(cur_row_r + 1'b1);
              end
            end
          end
          CMD_WRITE: begin
            if (pos_ok) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = addr_pos;
              ram_req.wdata = {item_r.color, item_r.char_code};
            end
          end
          CMD_CLEAR: begin
            base_nxt      = '0;
            cur_row_nxt   = '0;
            cur_col_nxt   = '0;
            fill_addr_nxt = '0;
            fill_last_nxt = ADDR_W'(CELL_COUNT - 1);
            fill_cell_nxt = {item_r.color, BLANK_CHAR};
            state_nxt     = ST_FILL;
          end
          CMD_READ: begin
            if (pos_ok) begin
              ram_req.re    = 1'b1;
              ram_req.raddr = addr_pos;
              state_nxt     = ST_READ;
            end
          end
        endcase
      end
      ST_READ: begin
        res_data_nxt = ram_rdata;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res = '{cell_data: res_data_r, pos_row: cur_row_r, pos_col: cur_col_r};

  `TCS_ASSERT(a_cursor_range, (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS), "cursor out of range")
  `TCS_ASSERT(a_base_range, int'(base_r) < ROWS, "row rotation pointer out of range")
  `TCS_ASSERT(a_waddr_range, ram_req.we |-> (int'(ram_req.waddr) < CELL_COUNT), "cell write outside store")
  `TCS_ASSERT(a_accept_exec, (in_valid && !in_stall) |=> (state_r == ST_EXEC), "accepted item not executed")
  `TCS_ASSERT(a_fill_order, ((state_r == ST_FILL) || (state_r == ST_INIT)) |-> (fill_addr_r <= fill_last_r), "fill sweep overran its end")

endmodule

`default_nettype wire

// File: hdl/text_console_with_scroll.sv
// ----------------------------------------------------------------------------
// text_console_with_scroll
// rows-by-columns text console with teletype cursor, scrolling and cell access
// ----------------------------------------------------------------------------
// One item at a time. A teletype character, a cell write or an off-screen cell
// read goes from acceptance through an execute state to the result state, an
// on-screen cell read also through a read state that captures the cell, and
// the next item is taken in the cycle after the result moves into the output
// register. A teletype character that scrolls also runs a fill sweep: rows
// rotate through a top-row pointer, so only the incoming blank row of COLUMNS
// cells is written, one cell a cycle through the single write port of the
// cell store. A clear sweeps all ROWS*COLUMNS cells for the same reason.
// After reset the cell store is swept to blanks in color 31, during which no
// item is accepted; color register writes are taken at any time.
`default_nettype none

module text_console_with_scroll (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_color,
  input  logic [4:0] in_row,
  input  logic [6:0] in_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_cell_data,
  output logic [4:0]  out_cursor_row_out,
  output logic [6:0]  out_cursor_col_out
);

  import tcs_pkg::*;

  logic [CHAR_W-1:0] tty_attr_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  item_t             in_item;
  result_t           res;
  logic              res_valid;
  logic              res_take;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tty_attr_r <= RESET_COLOR;
    end else if (cfg_wr_en) begin
      tty_attr_r <= cfg_wr_data;
    end
  end

  always_comb begin
    in_item.command   = cmd_t'(in_command);
    in_item.char_code = in_char_code;
    in_item.color     = in_color;
    in_item.row       = in_row;
    in_item.col       = in_col;
  end

  tcs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_item       (in_item),
    .in_stall      (in_stall),
    .tty_attr      (tty_attr_r),
    .res_valid     (res_valid),
    .res           (res),
    .res_take      (res_take),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata)
  );

  tcs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register frees the sequencer while a result waits
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_data      = out_res_r.cell_data;
  assign out_cursor_row_out = out_res_r.pos_row;
  assign out_cursor_col_out = out_res_r.pos_col;

endmodule

`default_nettype wire
